[rtl/core/wafb_pkg.sv]
// Shared types and constants of the wavelet analysis filter bank stage.
`default_nettype none

package wafb_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int INDEX_W     = 5;
   localparam int CFG_W       = 6;
   localparam int PROD_W      = 32;
   localparam int BAND_W      = 36;
   localparam int GROUP_SIZE  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int LEN_MIN     = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = 6'd2;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef enum logic {
      OP_EMIT,
      OP_LOAD
   } wafb_kind_type;

   typedef struct packed {
      wafb_kind_type              kind;
      logic                       end_flag;
      logic [INDEX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } wafb_op_type;

endpackage

`default_nettype wire

[rtl/core/wavelet_analysis_filter_bank_stage_top.sv]
// Top level of one two-band wavelet analysis filter bank stage.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   func, sample, last_sample, coef_index, coef_value
//   rsp      out        rsp_valid / rsp_ready   low_band, high_band, end_of_signal
//   csr      in         csr_valid / csr_ready   filter_length
//
// One item per cycle is accepted while req_ready is high; results pass the queue and the
// registered stages s0, s1, s2 and rsp. After a last sample, req_ready stays low in tail
// flush: L-1 zero samples go through the delay line, one a cycle unless the queue is full.
// Reset is synchronous and clears the delay line and control; the coefficient store is left
// as is. A stalled rsp freezes the datapath; the two-entry queue then fills and stalls req.
`default_nettype none

module wavelet_analysis_filter_bank_stage_top import wafb_pkg::*; #(
   parameter int MAX_TAPS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   input  logic [INDEX_W-1:0]         req_coef_index,
   input  logic signed [COEF_W-1:0]   req_coef_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [BAND_W-1:0]   rsp_low_band,
   output logic signed [BAND_W-1:0]   rsp_high_band,
   output logic                       rsp_end_of_signal,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_filter_length
);

   localparam int LenW    = $clog2(MAX_TAPS + 1);
   localparam int TOP_LEN = (MAX_TAPS / 2) * 2;

   logic [CFG_W-1:0]           length_ff;
   logic [LenW-1:0]            taps_in_use;

   logic                       push;
   logic                       q_in_ready;
   wafb_op_type                push_op;
   logic signed [SAMPLE_W-1:0] push_taps [MAX_TAPS];
   logic                       q_valid;
   logic                       q_ready;
   wafb_op_type                head_op;
   logic signed [SAMPLE_W-1:0] head_taps [MAX_TAPS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         length_ff <= csr_filter_length;
      end
   end

   // drop bit 0 and clamp to the supported range
   always_comb begin
      int len_i;
      len_i = int'({length_ff[CFG_W-1:1], 1'b0});
      if (len_i < LEN_MIN) begin
         len_i = LEN_MIN;
      end
      if (len_i > TOP_LEN) begin
         len_i = TOP_LEN;
      end
      taps_in_use = LenW'(len_i);
   end

   wafb_front #(.MAX_TAPS(MAX_TAPS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .taps_in_use     (taps_in_use),
      .q_ready         (q_in_ready),
      .q_push          (push),
      .q_op            (push_op),
      .q_taps          (push_taps)
   );

   wafb_queue #(.MAX_TAPS(MAX_TAPS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (q_in_ready),
      .in_op     (push_op),
      .in_taps   (push_taps),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_op    (head_op),
      .out_taps  (head_taps)
   );

   wafb_back #(.MAX_TAPS(MAX_TAPS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_op              (head_op),
      .q_taps            (head_taps),
      .taps_in_use       (taps_in_use),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_low_band      (rsp_low_band),
      .rsp_high_band     (rsp_high_band),
      .rsp_end_of_signal (rsp_end_of_signal)
   );

endmodule

`default_nettype wire

[rtl/core/wafb_front.sv]
// Front end: accepts items, runs the delay line and tail flush, issues operations.
`default_nettype none

module wafb_front import wafb_pkg::*; #(
   parameter int MAX_TAPS = 32,
   localparam int LenW = $clog2(MAX_TAPS + 1),
   localparam int CntW = $clog2(MAX_TAPS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   input  logic [INDEX_W-1:0]         req_coef_index,
   input  logic signed [COEF_W-1:0]   req_coef_value,
   input  logic [LenW-1:0]            taps_in_use,
   input  logic                       q_ready,
   output logic                       q_push,
   output wafb_op_type                q_op,
   output logic signed [SAMPLE_W-1:0] q_taps [MAX_TAPS]
);

   logic signed [SAMPLE_W-1:0] dl_ff    [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] dl_in    [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] dl_shift [MAX_TAPS];
   logic                       odd_ff, odd_in;
   logic                       flush_ff, flush_in;
   logic [CntW-1:0]            remain_ff, remain_in;

   logic                       accept;
   logic                       step;
   logic                       load;
   logic signed [SAMPLE_W-1:0] shift_val;
   logic [LenW-1:0]            remain_len;

   always_comb begin
      req_ready  = !flush_ff && q_ready;
      accept     = req_valid && req_ready;
      load       = accept && (req_func == FUNC_LOAD);
      shift_val  = flush_ff ? '0 : req_sample;
      if (flush_ff) begin
         step = q_ready || odd_ff;
      end else begin
         step = accept && (req_func == FUNC_SAMPLE);
      end
      remain_len = flush_ff ? LenW'(remain_ff) : taps_in_use;

      dl_shift[0] = shift_val;
      for (int k = 1; k < MAX_TAPS; k++) begin
         dl_shift[k] = dl_ff[k-1];
      end

      q_push            = load || (step && !odd_ff);
      q_op.kind         = load ? OP_LOAD : OP_EMIT;
      q_op.end_flag     = (flush_ff || req_last_sample) && (remain_len <= LenW'(2));
      q_op.coef_index   = req_coef_index;
      q_op.coef_value   = req_coef_value;
      q_taps            = dl_shift;
   end

   always_comb begin
      dl_in     = dl_ff;
      odd_in    = odd_ff;
      flush_in  = flush_ff;
      remain_in = remain_ff;
      if (step) begin
         dl_in  = dl_shift;
         odd_in = !odd_ff;
         if (flush_ff) begin
            remain_in = remain_ff - CntW'(1);
            if (remain_ff == CntW'(1)) begin
               flush_in = 1'b0;
               odd_in   = 1'b0;
               dl_in    = '{default: '0};
            end
         end else if (req_last_sample) begin
            flush_in  = 1'b1;
            remain_in = CntW'(taps_in_use - LenW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff     <= '{default: '0};
         odd_ff    <= 1'b0;
         flush_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         dl_ff     <= dl_in;
         odd_ff    <= odd_in;
         flush_ff  <= flush_in;
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/wafb_queue.sv]
// Two-entry operation queue between the front end and the filter datapath.
`default_nettype none

module wafb_queue import wafb_pkg::*; #(
   parameter int MAX_TAPS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  wafb_op_type                in_op,
   input  logic signed [SAMPLE_W-1:0] in_taps [MAX_TAPS],
   output logic                       out_valid,
   input  logic                       out_ready,
   output wafb_op_type                out_op,
   output logic signed [SAMPLE_W-1:0] out_taps [MAX_TAPS]
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   wafb_op_type                op_ff   [QUEUE_DEPTH];
   logic signed [SAMPLE_W-1:0] taps_ff [QUEUE_DEPTH][MAX_TAPS];
   logic [PtrW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]            count_ff, count_in;
   logic                       push;
   logic                       pop;

   always_comb begin
      in_ready  = count_ff != CntW'(QUEUE_DEPTH);
      out_valid = count_ff != '0;
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      out_op    = op_ff[rd_ptr_ff];
      out_taps  = taps_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= in_op;
         taps_ff[wr_ptr_ff] <= in_taps;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue fill count lost an item");

   a_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CntW'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

[rtl/core/wafb_back.sv]
// Back end: coefficient store, parallel tap multipliers and registered adder tree.
`default_nettype none

module wafb_back import wafb_pkg::*; #(
   parameter int MAX_TAPS = 32,
   localparam int LenW = $clog2(MAX_TAPS + 1),
   localparam int IdxW = $clog2(MAX_TAPS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  wafb_op_type                q_op,
   input  logic signed [SAMPLE_W-1:0] q_taps [MAX_TAPS],
   input  logic [LenW-1:0]            taps_in_use,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [BAND_W-1:0]   rsp_low_band,
   output logic signed [BAND_W-1:0]   rsp_high_band,
   output logic                       rsp_end_of_signal
);

   localparam int NumGroups = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

   logic signed [COEF_W-1:0]   coef_ff [MAX_TAPS];

   logic                       s0_valid_ff, s0_end_ff;
   logic signed [SAMPLE_W-1:0] xa_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] xb_ff [MAX_TAPS];
   logic signed [COEF_W-1:0]   hc_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] xa_in [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] xb_in [MAX_TAPS];
   logic signed [COEF_W-1:0]   hc_in [MAX_TAPS];

   logic                       s1_valid_ff, s1_end_ff;
   logic signed [PROD_W-1:0]   plo_ff [MAX_TAPS];
   logic signed [PROD_W-1:0]   phi_ff [MAX_TAPS];

   logic                       s2_valid_ff, s2_end_ff;
   logic signed [BAND_W-1:0]   glo_ff [NumGroups];
   logic signed [BAND_W-1:0]   ghi_ff [NumGroups];
   logic signed [BAND_W-1:0]   glo_in [NumGroups];
   logic signed [BAND_W-1:0]   ghi_in [NumGroups];

   logic                       rsp_valid_ff, rsp_end_ff;
   logic signed [BAND_W-1:0]   rsp_lo_ff, rsp_lo_in;
   logic signed [BAND_W-1:0]   rsp_hi_ff, rsp_hi_in;

   logic                       en;
   logic                       pop;

   assign en      = !rsp_valid_ff || rsp_ready;
   assign q_ready = en;
   assign pop     = q_valid && en;

   // select direct and reversed taps, zero those beyond the filter length
   always_comb begin
      logic [31:0] ridx;
      for (int k = 0; k < MAX_TAPS; k++) begin
         ridx = 32'(taps_in_use) - 32'd1 - 32'(k);
         if (k < int'(taps_in_use)) begin
            xa_in[k] = q_taps[k];
            xb_in[k] = q_taps[ridx[IdxW-1:0]];
            hc_in[k] = coef_ff[k];
         end else begin
            xa_in[k] = '0;
            xb_in[k] = '0;
            hc_in[k] = '0;
         end
      end
   end

   always_comb begin
      logic signed [BAND_W-1:0] acc_lo;
      logic signed [BAND_W-1:0] acc_hi;
      for (int g = 0; g < NumGroups; g++) begin
         acc_lo = '0;
         acc_hi = '0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            if (g * GROUP_SIZE + i < MAX_TAPS) begin
               acc_lo = acc_lo + BAND_W'(plo_ff[g * GROUP_SIZE + i]);
               if (((g * GROUP_SIZE + i) % 2) == 1) begin
                  acc_hi = acc_hi + BAND_W'(phi_ff[g * GROUP_SIZE + i]);
               end else begin
                  acc_hi = acc_hi - BAND_W'(phi_ff[g * GROUP_SIZE + i]);
               end
            end
         end
         glo_in[g] = acc_lo;
         ghi_in[g] = acc_hi;
      end
   end

   always_comb begin
      rsp_lo_in = '0;
      rsp_hi_in = '0;
      for (int g = 0; g < NumGroups; g++) begin
         rsp_lo_in = rsp_lo_in + glo_ff[g];
         rsp_hi_in = rsp_hi_in + ghi_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff  <= pop && (q_op.kind == OP_EMIT);
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_end_ff  <= q_op.end_flag;
         xa_ff      <= xa_in;
         xb_ff      <= xb_in;
         hc_ff      <= hc_in;
         s1_end_ff  <= s0_end_ff;
         for (int k = 0; k < MAX_TAPS; k++) begin
            plo_ff[k] <= xa_ff[k] * hc_ff[k];
            phi_ff[k] <= xb_ff[k] * hc_ff[k];
         end
         s2_end_ff  <= s1_end_ff;
         glo_ff     <= glo_in;
         ghi_ff     <= ghi_in;
         rsp_end_ff <= s2_end_ff;
         rsp_lo_ff  <= rsp_lo_in;
         rsp_hi_ff  <= rsp_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         if (pop && (q_op.kind == OP_LOAD) && (32'(q_op.coef_index) == k)) begin
            coef_ff[k] <= q_op.coef_value;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_low_band      = rsp_lo_ff;
   assign rsp_high_band     = rsp_hi_ff;
   assign rsp_end_of_signal = rsp_end_ff;

endmodule

`default_nettype wire
